@@ rtl/cfcd_pkg.sv @@
// Shared types, constants and the CRC byte update for the COBS/CRC-16 frame decoder.
`default_nettype none
package cfcd_pkg;

	// Frame counter width (encoded and forwarded bytes)
	localparam int COUNT_WIDTH = 12;
	// Width of the payload_length and max_raw_length fields
	localparam int LEN_WIDTH = 12;
	// Width used to compare counts against the limit
	localparam int CMP_WIDTH = 16;

	localparam logic [7:0] DELIM_BYTE = 8'h00;
	localparam logic [7:0] FULL_CODE = 8'hFF;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [LEN_WIDTH-1:0] MAX_RAW_RESET = LEN_WIDTH'(1200);
	localparam logic [CMP_WIDTH-1:0] COUNT_MAX = CMP_WIDTH'((1 << COUNT_WIDTH) - 1);

	typedef enum logic [2:0] {
		STATUS_GOOD     = 3'd0,
		STATUS_COBS_ERR = 3'd1,
		STATUS_SHORT    = 3'd2,
		STATUS_CRC_ERR  = 3'd3,
		STATUS_OVERFLOW = 3'd4
	} status_t;

	typedef struct packed {
		logic                 is_end;
		logic [7:0]           data;
		status_t              status;
		logic [LEN_WIDTH-1:0] length;
	} result_t;

	// CRC-16/CCITT-FALSE update over one byte, MSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] d);
		logic [15:0] c;
		c = crc ^ {d, 8'h00};
		for (int b = 0; b < 8; b++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

@@ rtl/cfcd_out_skid.sv @@
// Two-entry output buffer: result register plus skid register.
`default_nettype none
module cfcd_out_skid (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      push,
	input  cfcd_pkg::result_t        push_data,
	input  wire                      out_stall,
	output logic                     out_valid,
	output cfcd_pkg::result_t        out_data,
	output logic                     full
);

	logic              out_valid_q;
	logic              skid_valid_q;
	cfcd_pkg::result_t out_q;
	cfcd_pkg::result_t skid_q;
	logic              take;

	assign take      = out_valid_q && !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign full      = skid_valid_q;

	// Advance the output register; park a beat in the skid when the output holds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (take) begin
					skid_valid_q <= 1'b0;
				end
			end else if (push && out_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end
			if (!out_valid_q || take) begin
				out_valid_q <= skid_valid_q || push;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (!out_valid_q || take) begin
			out_q <= skid_valid_q ? skid_q : push_data;
		end
		if (!skid_valid_q && push && out_valid_q && !take) begin
			skid_q <= push_data;
		end
	end

endmodule
`default_nettype wire

@@ rtl/cobs_crc16_frame_decoder_unit.sv @@
// Top level of the COBS frame decoder with CRC-16/CCITT-FALSE check.
//
// Input channel: one received byte per beat on rx_byte (in_valid/in_stall);
// 0x00 ends a frame. Output channel: one result per beat (out_valid/out_stall),
// either a payload byte (is_end = 0, out_data) or an end item (is_end = 1,
// frame_status, payload_length). Payload bytes leave speculatively; drop the
// frame when the end status is not good. Empty frames give no result.
// Configuration: cfg_data written on cfg_valid (cfg_ready is always high)
// sets max_raw_length; write it only while the block is idle.
// Throughput: one byte per cycle while in_stall is low. The COBS group
// tracking, the two-byte hold-back and the byte-wide CRC update are all
// combinational between the frame state registers and the output register.
// Each result goes to the output register, or to the skid while it holds.
// Stall: a two-entry output buffer absorbs one extra result; in_stall rises
// only when both entries are full and falls once the consumer takes a beat.
// Reset: clears frame state, empties the buffer, sets max_raw_length to 1200.
`default_nettype none
module cobs_crc16_frame_decoder_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [7:0]  rx_byte,
	output logic        out_valid,
	input  wire         out_stall,
	output logic        is_end,
	output logic [7:0]  out_data,
	output logic [2:0]  frame_status,
	output logic [11:0] payload_length,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [11:0] cfg_data
);

	localparam int CW = cfcd_pkg::COUNT_WIDTH;
	localparam int LW = cfcd_pkg::LEN_WIDTH;
	localparam int MW = cfcd_pkg::CMP_WIDTH;

	logic [LW-1:0] max_raw_q;
	logic [7:0]    group_rem_q, group_rem_d;
	logic          zero_pend_q, zero_pend_d;
	logic [7:0]    held0_q, held0_d;
	logic [7:0]    held1_q, held1_d;
	logic [1:0]    held_cnt_q, held_cnt_d;
	logic [15:0]   crc_q, crc_d;
	logic [CW-1:0] raw_cnt_q, raw_cnt_d;
	logic [CW-1:0] pay_cnt_q, pay_cnt_d;

	logic              accept;
	logic              res_push;
	cfcd_pkg::result_t res;
	cfcd_pkg::result_t out_res;
	logic              buf_full;
	logic [MW-1:0]     limit;
	logic [MW-1:0]     pay_cnt_w;
	logic              push_en;
	logic [7:0]        push_byte;

	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign pay_cnt_w = MW'(pay_cnt_q);
	assign limit     = (MW'(max_raw_q) < cfcd_pkg::COUNT_MAX) ? MW'(max_raw_q)
	                                                           : cfcd_pkg::COUNT_MAX;

	// Hold the frame length limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_raw_q <= cfcd_pkg::MAX_RAW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_raw_q <= cfg_data;
		end
	end

	// Decode one byte: delimiter, overflow, code byte or data byte
	always_comb begin
		group_rem_d = group_rem_q;
		zero_pend_d = zero_pend_q;
		held0_d     = held0_q;
		held1_d     = held1_q;
		held_cnt_d  = held_cnt_q;
		crc_d       = crc_q;
		raw_cnt_d   = raw_cnt_q;
		pay_cnt_d   = pay_cnt_q;
		res_push    = 1'b0;
		res.is_end  = 1'b1;
		res.data    = 8'h00;
		res.status  = cfcd_pkg::STATUS_GOOD;
		res.length  = pay_cnt_w[LW-1:0];
		push_en     = 1'b0;
		push_byte   = rx_byte;
		if (rx_byte == cfcd_pkg::DELIM_BYTE || MW'(raw_cnt_q) >= limit) begin
			if (rx_byte != cfcd_pkg::DELIM_BYTE) begin
				res_push   = 1'b1;
				res.status = cfcd_pkg::STATUS_OVERFLOW;
			end else if (raw_cnt_q != '0) begin
				res_push = 1'b1;
				if (group_rem_q != 8'd0) begin
					res.status = cfcd_pkg::STATUS_COBS_ERR;
				end else if (held_cnt_q < 2'd2) begin
					res.status = cfcd_pkg::STATUS_SHORT;
				end else if ({held1_q, held0_q} != crc_q) begin
					res.status = cfcd_pkg::STATUS_CRC_ERR;
				end
			end
			// Drop all frame state
			group_rem_d = 8'd0;
			zero_pend_d = 1'b0;
			held0_d     = 8'h00;
			held1_d     = 8'h00;
			held_cnt_d  = 2'd0;
			crc_d       = cfcd_pkg::CRC_INIT;
			raw_cnt_d   = '0;
			pay_cnt_d   = '0;
		end else begin
			raw_cnt_d = raw_cnt_q + CW'(1);
			if (group_rem_q == 8'd0) begin
				group_rem_d = rx_byte - 8'd1;
				zero_pend_d = (rx_byte != cfcd_pkg::FULL_CODE);
				push_en     = zero_pend_q && (raw_cnt_q != '0);
				push_byte   = 8'h00;
			end else begin
				group_rem_d = group_rem_q - 8'd1;
				push_en     = 1'b1;
			end
			// Shift a decoded byte through the hold-back pair
			if (push_en) begin
				if (held_cnt_q < 2'd2) begin
					if (held_cnt_q[0]) begin
						held1_d = push_byte;
					end else begin
						held0_d = push_byte;
					end
					held_cnt_d = held_cnt_q + 2'd1;
				end else begin
					res_push   = 1'b1;
					res.is_end = 1'b0;
					res.data   = held0_q;
					res.length = '0;
					crc_d      = cfcd_pkg::crc_byte(crc_q, held0_q);
					pay_cnt_d  = pay_cnt_q + CW'(1);
					held0_d    = held1_q;
					held1_d    = push_byte;
				end
			end
		end
	end

	// Advance frame state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_rem_q <= 8'd0;
			zero_pend_q <= 1'b0;
			held0_q     <= 8'h00;
			held1_q     <= 8'h00;
			held_cnt_q  <= 2'd0;
			crc_q       <= cfcd_pkg::CRC_INIT;
			raw_cnt_q   <= '0;
			pay_cnt_q   <= '0;
		end else if (accept) begin
			group_rem_q <= group_rem_d;
			zero_pend_q <= zero_pend_d;
			held0_q     <= held0_d;
			held1_q     <= held1_d;
			held_cnt_q  <= held_cnt_d;
			crc_q       <= crc_d;
			raw_cnt_q   <= raw_cnt_d;
			pay_cnt_q   <= pay_cnt_d;
		end
	end

	cfcd_out_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && res_push),
		.push_data (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_res),
		.full      (buf_full)
	);

	assign in_stall       = buf_full;
	assign is_end         = out_res.is_end;
	assign out_data       = out_res.data;
	assign frame_status   = out_res.status;
	assign payload_length = out_res.length;

	// A fresh frame has no partial group and nothing held back
	a_fresh_frame: assert property (@(posedge clk) disable iff (!arst_n)
		raw_cnt_q == '0 |-> group_rem_q == 8'd0 && held_cnt_q == 2'd0 && !zero_pend_q)
		else $error("frame state not clear at frame start");

	// Hold-back pair never exceeds two bytes
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_cnt_q <= 2'd2)
		else $error("held byte count out of range");

	// Payload beats carry no status and no length
	a_payload_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_end |-> frame_status == cfcd_pkg::STATUS_GOOD &&
			payload_length == 12'd0)
		else $error("payload beat carries end fields");

	// Input stalls only while a result already waits at the output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output");

	// A full buffer with a stalled consumer stays full
	a_buf_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && out_stall |=> in_stall)
		else $error("skid entry lost under stall");

endmodule
`default_nettype wire
